@@ rtl/dbdf_pkg.sv @@
// Shared types and constants for the detection box decode filter.
package dbdf_pkg;

  localparam int NUM_CLASSES_DEF = 13;
  localparam int NUM_ANCHORS_DEF = 8400;

  localparam int VALUE_W  = 24;
  localparam int POS_W    = 5;
  localparam int ANCHOR_W = 14;
  localparam int CLASS_W  = 4;
  localparam int CONF_W   = 23;
  localparam int PIX_W    = 14;
  localparam int PAD_W    = 10;
  localparam int SCALE_W  = 16;
  localparam int FRAC_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Q24 products: centre term is 25 x 17 bits, size term is 24 x 17 bits.
  localparam int CQ_W = 42;
  localparam int SQ_W = 41;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCORE_THRESHOLD = 3'd0,
    CFG_PAD_X           = 3'd1,
    CFG_PAD_Y           = 3'd2,
    CFG_SCALE_X         = 3'd3,
    CFG_SCALE_Y         = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CONF_W-1:0]  score_threshold;
    logic [PAD_W-1:0]   pad_x;
    logic [PAD_W-1:0]   pad_y;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
  } cfg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      frame_start;
  } in_word_t;

  typedef struct packed {
    logic [ANCHOR_W-1:0] anchor_index;
    logic [CLASS_W-1:0]  class_id;
    logic [CONF_W-1:0]   confidence;
    logic [PIX_W-1:0]    box_left;
    logic [PIX_W-1:0]    box_top;
    logic [PIX_W-1:0]    box_width;
    logic [PIX_W-1:0]    box_height;
  } out_word_t;

  // One anchor that passed the score test, with its raw box values.
  typedef struct packed {
    logic [ANCHOR_W-1:0]       anchor_index;
    logic [CLASS_W-1:0]        class_id;
    logic [CONF_W-1:0]         confidence;
    logic signed [VALUE_W-1:0] cx;
    logic signed [VALUE_W-1:0] cy;
    logic signed [VALUE_W-1:0] w;
    logic signed [VALUE_W-1:0] h;
  } dec_t;

endpackage

@@ rtl/dbdf_track.sv @@
// Element tracking: counters, box capture, best class search and score test.
module dbdf_track #(
  parameter int NUM_CLASSES = dbdf_pkg::NUM_CLASSES_DEF,
  parameter int NUM_ANCHORS = dbdf_pkg::NUM_ANCHORS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dbdf_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  dbdf_pkg::in_word_t in_word,
  output logic              dec_valid,
  input  logic              dec_ready,
  output dbdf_pkg::dec_t    dec_word
);
  import dbdf_pkg::*;

  localparam int NumBox = 4;
  localparam logic [POS_W-1:0] LastPos = POS_W'(NumBox - 1 + NUM_CLASSES);
  localparam logic [POS_W-1:0] FirstScore = POS_W'(NumBox);

  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [ANCHOR_W-1:0]       anchor_r, anchor_nxt;
  logic signed [VALUE_W-1:0] box_r [NumBox];
  logic signed [VALUE_W-1:0] best_r, best_nxt;
  logic [CLASS_W-1:0]        class_r, class_nxt;
  logic                      dec_valid_r, dec_valid_nxt;
  dec_t                      dec_r, dec_nxt;

  logic                      accept;
  logic [POS_W-1:0]          pos_eff;
  logic [ANCHOR_W-1:0]       anchor_eff;
  logic [POS_W-1:0]          cls_full;
  logic                      is_score;
  logic                      is_last;
  logic                      pass;
  logic [ANCHOR_W:0]         anchor_inc;

  assign in_stall  = dec_valid_r && !dec_ready;
  assign accept    = in_valid && !in_stall;
  assign dec_valid = dec_valid_r;
  assign dec_word  = dec_r;

  always_comb begin
    pos_eff    = in_word.frame_start ? '0 : pos_r;
    anchor_eff = in_word.frame_start ? '0 : anchor_r;
    cls_full   = pos_eff - FirstScore;
    is_score   = (pos_eff >= FirstScore);
    is_last    = (pos_eff >= LastPos);

    best_nxt  = best_r;
    class_nxt = class_r;
    if (is_score && ((cls_full == '0) || (in_word.value > best_r))) begin
      best_nxt  = in_word.value;
      class_nxt = cls_full[CLASS_W-1:0];
    end

    // A negative best score never passes since the threshold is unsigned.
    pass = (best_nxt >= $signed({1'b0, cfg.score_threshold}));

    anchor_inc = {1'b0, anchor_eff} + (ANCHOR_W+1)'(1);
    if (is_last) begin
      pos_nxt    = '0;
      anchor_nxt = (anchor_inc >= (ANCHOR_W+1)'(NUM_ANCHORS)) ? '0
                                                             : anchor_inc[ANCHOR_W-1:0];
    end else begin
      pos_nxt    = pos_eff + POS_W'(1);
      anchor_nxt = anchor_eff;
    end

    dec_nxt.anchor_index = anchor_eff;
    dec_nxt.class_id     = class_nxt;
    dec_nxt.confidence   = best_nxt[CONF_W-1:0];
    dec_nxt.cx           = box_r[0];
    dec_nxt.cy           = box_r[1];
    dec_nxt.w            = box_r[2];
    dec_nxt.h            = box_r[3];

    dec_valid_nxt = (dec_valid_r && !dec_ready) || (accept && is_last && pass);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      anchor_r    <= '0;
      dec_valid_r <= 1'b0;
    end else begin
      dec_valid_r <= dec_valid_nxt;
      if (accept) begin
        pos_r    <= pos_nxt;
        anchor_r <= anchor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      best_r  <= best_nxt;
      class_r <= class_nxt;
      if (!is_score) begin
        box_r[pos_eff[1:0]] <= in_word.value;
      end
      if (is_last && pass) begin
        dec_r <= dec_nxt;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LastPos)
    else $error("element position ran past the last score");

  a_anchor_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, anchor_r} < (ANCHOR_W+1)'(NUM_ANCHORS))
    else $error("anchor counter ran past the anchor count");

  a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid_r && !dec_ready |=> dec_valid_r && $stable(dec_r))
    else $error("pending anchor lost or changed while waiting");

  a_dec_pass: assert property (@(posedge clk) disable iff (!rst_n)
    dec_valid_r |-> dec_r.confidence >= cfg.score_threshold)
    else $error("anchor below threshold forwarded");

endmodule

@@ rtl/dbdf_scale.sv @@
// Box rescale: multiply stage, then edge, size and saturation into the result register.
module dbdf_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  dbdf_pkg::cfg_t     cfg,
  input  logic               dec_valid,
  output logic               dec_ready,
  input  dbdf_pkg::dec_t     dec_word,
  output logic               out_valid,
  input  logic               out_stall,
  output dbdf_pkg::out_word_t out_word
);
  import dbdf_pkg::*;

  localparam int TW_W = CQ_W + 2;
  localparam int EDGE_SHIFT = 2 * FRAC_W + 1;
  localparam int SIZE_SHIFT = 2 * FRAC_W;
  localparam int EP_W = TW_W - 1 - EDGE_SHIFT;
  localparam int SP_W = SQ_W - 1 - SIZE_SHIFT;

  typedef struct packed {
    logic [ANCHOR_W-1:0]    anchor_index;
    logic [CLASS_W-1:0]     class_id;
    logic [CONF_W-1:0]      confidence;
    logic signed [CQ_W-1:0] xq;
    logic signed [CQ_W-1:0] yq;
    logic signed [SQ_W-1:0] wq;
    logic signed [SQ_W-1:0] hq;
  } prod_t;

  logic      m_valid_r, m_valid_nxt;
  prod_t     m_r, m_nxt;
  logic      o_valid_r, o_valid_nxt;
  out_word_t o_r, o_nxt;

  logic                      out_ready;
  logic                      m_adv;
  logic                      keep;
  logic signed [VALUE_W:0]   cx_off, cy_off;
  logic signed [SCALE_W:0]   sx, sy;
  logic [TW_W-1:0]           twice_x, twice_y;

  function automatic logic [PIX_W-1:0] edge_pix(input logic [TW_W-1:0] tw);
    logic [EP_W-1:0] p;
    p = tw[TW_W-2:EDGE_SHIFT];
    if (tw[TW_W-1]) begin
      return '0;
    end else if (|p[EP_W-1:PIX_W]) begin
      return '1;
    end else begin
      return p[PIX_W-1:0];
    end
  endfunction

  function automatic logic [PIX_W-1:0] size_pix(input logic [SQ_W-1:0] q);
    logic [SP_W-1:0] p;
    p = q[SQ_W-2:SIZE_SHIFT];
    if (q[SQ_W-1]) begin
      return '0;
    end else if (|p[SP_W-1:PIX_W]) begin
      return '1;
    end else begin
      return p[PIX_W-1:0];
    end
  endfunction

  assign out_ready = !o_valid_r || !out_stall;
  assign m_adv     = m_valid_r && (!keep || out_ready);
  assign dec_ready = !m_valid_r || m_adv;
  assign out_valid = o_valid_r;
  assign out_word  = o_r;

  // Multiply stage: centre minus padding, and both sizes, times the scale.
  always_comb begin
    sx     = $signed({1'b0, cfg.scale_x});
    sy     = $signed({1'b0, cfg.scale_y});
    cx_off = $signed({dec_word.cx[VALUE_W-1], dec_word.cx})
           - $signed({3'b000, cfg.pad_x, {FRAC_W{1'b0}}});
    cy_off = $signed({dec_word.cy[VALUE_W-1], dec_word.cy})
           - $signed({3'b000, cfg.pad_y, {FRAC_W{1'b0}}});
    m_nxt.anchor_index = dec_word.anchor_index;
    m_nxt.class_id     = dec_word.class_id;
    m_nxt.confidence   = dec_word.confidence;
    m_nxt.xq           = cx_off * sx;
    m_nxt.yq           = cy_off * sy;
    m_nxt.wq           = dec_word.w * sx;
    m_nxt.hq           = dec_word.h * sy;
    m_valid_nxt        = (m_valid_r && !m_adv) || (dec_valid && dec_ready);
  end

  // Edge stage: twice the left edge is 2*centre - size, all in Q24.
  always_comb begin
    twice_x = {m_r.xq[CQ_W-1], m_r.xq, 1'b0} - {{3{m_r.wq[SQ_W-1]}}, m_r.wq};
    twice_y = {m_r.yq[CQ_W-1], m_r.yq, 1'b0} - {{3{m_r.hq[SQ_W-1]}}, m_r.hq};
    // A box narrower or lower than one pixel is dropped.
    keep = !m_r.wq[SQ_W-1] && (|m_r.wq[SQ_W-2:SIZE_SHIFT])
        && !m_r.hq[SQ_W-1] && (|m_r.hq[SQ_W-2:SIZE_SHIFT]);
    o_nxt.anchor_index = m_r.anchor_index;
    o_nxt.class_id     = m_r.class_id;
    o_nxt.confidence   = m_r.confidence;
    o_nxt.box_left     = edge_pix(twice_x);
    o_nxt.box_top      = edge_pix(twice_y);
    o_nxt.box_width    = size_pix(m_r.wq);
    o_nxt.box_height   = size_pix(m_r.hq);
    o_valid_nxt        = (o_valid_r && out_stall) || (m_adv && keep);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      m_valid_r <= m_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid && dec_ready) begin
      m_r <= m_nxt;
    end
    if (m_adv && keep) begin
      o_r <= o_nxt;
    end
  end

endmodule

@@ rtl/detection_box_decode_filter.sv @@
// Top level of the detection box decode filter: configuration registers and stage wiring.
//
// The block takes a detector head's output one 24-bit signed Q11.12 word per cycle,
// anchor by anchor: centre x, centre y, width, height, then one score per class.
// It keeps the box words, tracks the first largest class score as the scores arrive,
// and on the last score of an anchor tests the best score against score_threshold. An
// anchor that passes is rescaled to image pixels (padding removed, Q4.12 scale
// applied, left and top clamped at zero, all four values saturated at 16383) and is
// emitted only if its width and height are at least one pixel. A word with
// frame_start set restarts the anchor count at zero and drops any partial anchor.
// Sustained rate is one input word per clock, with no gaps, unless the receiver stalls.
// Once an anchor's last score is accepted, its result passes three registers: one holds
// the passing anchor, one holds the four scale products, and the output register holds
// the finished result. These three registers act as slack toward the result side, so
// in_stall rises only when all three hold anchors that the receiver has not taken.
// Configuration writes are always ready and should be made while the block is idle.
module detection_box_decode_filter #(
  parameter int NUM_CLASSES = dbdf_pkg::NUM_CLASSES_DEF,
  parameter int NUM_ANCHORS = dbdf_pkg::NUM_ANCHORS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dbdf_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dbdf_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dbdf_pkg::*;

  cfg_t cfg_r;
  logic dec_valid;
  logic dec_ready;
  dec_t dec_word;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  // Indexes past the last register are accepted and ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.score_threshold <= CONF_W'(410);
      cfg_r.pad_x           <= '0;
      cfg_r.pad_y           <= '0;
      cfg_r.scale_x         <= SCALE_W'(4096);
      cfg_r.scale_y         <= SCALE_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        CFG_SCORE_THRESHOLD: cfg_r.score_threshold <= cfg_data[CONF_W-1:0];
        CFG_PAD_X:           cfg_r.pad_x           <= cfg_data[PAD_W-1:0];
        CFG_PAD_Y:           cfg_r.pad_y           <= cfg_data[PAD_W-1:0];
        CFG_SCALE_X:         cfg_r.scale_x         <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_Y:         cfg_r.scale_y         <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Counters, box capture, best score and threshold test; passing anchors are held
  // in a single register until the scale stage takes them.
  dbdf_track #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_ANCHORS (NUM_ANCHORS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_word  (dec_word)
  );

  // Scale multiplies, then edge and size computation into the output register.
  dbdf_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_word  (dec_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ tb/detection_box_decode_filter_tb.sv @@
// Self-checking testbench for the detection box decode filter with a scoreboard class.
`timescale 1ns / 100ps

module detection_box_decode_filter_tb;
  import dbdf_pkg::*;

  localparam int CLASSES = NUM_CLASSES_DEF;
  localparam int ANCHORS = NUM_ANCHORS_DEF;
  // One anchor is four box words followed by one score word per class.
  localparam int ANCHOR_WORDS = 4 + CLASSES;
  localparam int PIX_LIMIT = 16383;
  localparam longint ONE_PIXEL_Q = longint'(1) << 24;
  // The quiet time before a register write covers an anchor that is still in
  // flight but will produce nothing, so the scoreboard alone cannot tell it is
  // there.
  localparam int RESULT_LATENCY = 3;
  localparam int QUIET_CYCLES = 4 * RESULT_LATENCY;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_WORDS = 190;
  localparam int LAST_ANCHORS = 2;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Register indexes past the last real register must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = CFG_IDX_W'(CFG_SCALE_Y + 1);
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = '1;

  // The scoreboard keeps its own copy of the registers and the anchor state,
  // decodes each anchor as its last score word is accepted, and holds the
  // detections that the block still owes.
  class box_decode_predictor;
    logic [CONF_W-1:0]  threshold;
    logic [PAD_W-1:0]   pad_x, pad_y;
    logic [SCALE_W-1:0] scale_x, scale_y;
    int unsigned        word_pos;
    int unsigned        anchor_count;
    longint             box[4];
    longint             best_score;
    int unsigned        best_class;
    out_word_t          expected_boxes[$];
    int unsigned        failures;

    function new();
      threshold = CONF_W'(410);
      pad_x = '0;
      pad_y = '0;
      scale_x = SCALE_W'(4096);
      scale_y = SCALE_W'(4096);
      word_pos = 0;
      anchor_count = 0;
      foreach (box[i]) box[i] = 0;
      best_score = 0;
      best_class = 0;
      failures = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCORE_THRESHOLD: threshold = data[CONF_W-1:0];
        CFG_PAD_X:           pad_x = data[PAD_W-1:0];
        CFG_PAD_Y:           pad_y = data[PAD_W-1:0];
        CFG_SCALE_X:         scale_x = data[SCALE_W-1:0];
        CFG_SCALE_Y:         scale_y = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // Left or top edge from a centre and a size, both Q24. The edge is worked
    // out at twice its value so that halving the size loses nothing.
    function int unsigned edge_pixels(longint centre_q, longint size_q);
      longint twice;
      twice = 2 * centre_q - size_q;
      if (twice < 0) return 0;
      return ((twice >>> 25) > PIX_LIMIT) ? PIX_LIMIT : int'(twice >>> 25);
    endfunction

    function int unsigned size_pixels(longint size_q);
      return ((size_q >>> 24) > PIX_LIMIT) ? PIX_LIMIT : int'(size_q >>> 24);
    endfunction

    function void note_word(in_word_t w);
      longint    v, xq, yq, wq, hq;
      out_word_t r;
      v = longint'($signed(w.value));
      if (w.frame_start) begin
        word_pos = 0;
        anchor_count = 0;
      end
      if (word_pos < 4) begin
        box[word_pos] = v;
      end else if (word_pos == 4 || v > best_score) begin
        // Only a strictly larger score displaces the leader, so ties keep
        // the lower class.
        best_score = v;
        best_class = word_pos - 4;
      end
      if (word_pos >= ANCHOR_WORDS - 1) begin
        if (best_score >= longint'(threshold)) begin
          xq = (box[0] - (longint'(pad_x) << FRAC_W)) * longint'(scale_x);
          yq = (box[1] - (longint'(pad_y) << FRAC_W)) * longint'(scale_y);
          wq = box[2] * longint'(scale_x);
          hq = box[3] * longint'(scale_y);
          if (wq >= ONE_PIXEL_Q && hq >= ONE_PIXEL_Q) begin
            r.anchor_index = ANCHOR_W'(anchor_count);
            r.class_id = CLASS_W'(best_class);
            r.confidence = CONF_W'(best_score);
            r.box_left = PIX_W'(edge_pixels(xq, wq));
            r.box_top = PIX_W'(edge_pixels(yq, hq));
            r.box_width = PIX_W'(size_pixels(wq));
            r.box_height = PIX_W'(size_pixels(hq));
            expected_boxes = {expected_boxes, r};
          end
        end
        word_pos = 0;
        anchor_count = (anchor_count + 1 >= ANCHORS) ? 0 : anchor_count + 1;
      end else begin
        word_pos++;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $error("%s expected %0d actual %0d", name, want, seen);
        failures++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_boxes.size() == 0) begin
        $error("unexpected result word for anchor %0d", got.anchor_index);
        failures++;
        return;
      end
      want = expected_boxes.pop_front();
      compare_field("anchor_index", want.anchor_index, got.anchor_index);
      compare_field("class_id", want.class_id, got.class_id);
      compare_field("confidence", want.confidence, got.confidence);
      compare_field("box_left", want.box_left, got.box_left);
      compare_field("box_top", want.box_top, got.box_top);
      compare_field("box_width", want.box_width, got.box_width);
      compare_field("box_height", want.box_height, got.box_height);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  box_decode_predictor box_decoder = new();
  // When clear, neither side inserts gaps or stalls.
  bit          idle_on;
  int unsigned stall_left;
  int unsigned cycle_count = 0;

  detection_box_decode_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result side stalls in random bursts. Stall changes at the falling edge
  // so that it is stable at the rising edge where the word is taken.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // A result word is taken at a rising edge with valid high and stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      box_decoder.check_result(out_word);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one input word from a falling edge and holds it until the block
  // takes it. Valid is left high so that the next word can follow at once.
  task automatic push_word(input in_word_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    box_decoder.note_word(w);
    @(negedge clk);
  endtask

  // Sends one anchor, or its first length words. Box words are mostly
  // plausible network coordinates, with small, zero, negative and arbitrary
  // sizes mixed in. Scores are built around one leading score that often sits
  // right at the threshold, and other classes often tie with it. A silent
  // anchor has only negative scores, so it only moves the anchor count.
  task automatic send_anchor(input bit with_start, input int unsigned length, input bit silent);
    in_word_t                  w;
    logic signed [VALUE_W-1:0] lead;
    int unsigned               lead_cls;
    lead_cls = $urandom_range(0, CLASSES - 1);
    case ($urandom_range(0, 3))
      0: lead = VALUE_W'(box_decoder.threshold + $urandom_range(0, 2) - 1);
      1: lead = VALUE_W'($urandom_range(0, 8192));
      2: lead = VALUE_W'($urandom);
      default: lead = VALUE_W'(box_decoder.threshold + $urandom_range(0, 4096));
    endcase
    for (int k = 0; k < length; k++) begin
      w.frame_start = with_start && (k == 0);
      if (k < 2) begin
        w.value = ($urandom_range(0, 7) != 0) ? VALUE_W'($urandom_range(0, 1400 << FRAC_W))
                                              : VALUE_W'($urandom);
      end else if (k < 4) begin
        case ($urandom_range(0, 9))
          6: w.value = VALUE_W'($urandom_range(0, 1 << (FRAC_W + 1)));
          7: w.value = VALUE_W'(0 - $urandom_range(1, 1 << 20));
          8: w.value = '0;
          9: w.value = VALUE_W'($urandom);
          default: w.value = VALUE_W'($urandom_range(1 << FRAC_W, 700 << FRAC_W));
        endcase
      end else if (silent) begin
        w.value = VALUE_W'(0 - $urandom_range(1, 1 << 22));
      end else if (k - 4 == lead_cls) begin
        w.value = lead;
      end else begin
        case ($urandom_range(0, 5))
          0: w.value = lead;
          1: w.value = VALUE_W'($urandom);
          default: w.value = VALUE_W'(lead - $urandom_range(1, 3000));
        endcase
      end
      push_word(w);
    end
  endtask

  // Completes any partial anchor, then waits until every owed detection has
  // arrived and the pipeline has had time to empty.
  task automatic settle();
    in_word_t w;
    while (box_decoder.word_pos != 0) begin
      w.value = VALUE_W'($urandom);
      w.frame_start = 1'b0;
      push_word(w);
    end
    in_valid <= 1'b0;
    while (box_decoder.expected_boxes.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no second
  // assignment in one time step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    box_decoder.write_register(idx, data);
    @(negedge clk);
  endtask

  // Writes all five registers plus one spare index that must be ignored. The
  // bits above each narrow register are random, so masking is exercised too.
  task automatic apply_settings(input logic [CONF_W-1:0] thr,
                                input logic [PAD_W-1:0] px, input logic [PAD_W-1:0] py,
                                input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy);
    logic [CFG_DATA_W-1:0] data;
    write_register(CFG_IDX_W'(SPARE_INDEX_LO
                              + $urandom_range(0, SPARE_INDEX_HI - SPARE_INDEX_LO)),
                   CFG_DATA_W'($urandom));
    write_register(CFG_SCORE_THRESHOLD, thr);
    data = CFG_DATA_W'($urandom);
    data[PAD_W-1:0] = px;
    write_register(CFG_PAD_X, data);
    data = CFG_DATA_W'($urandom);
    data[PAD_W-1:0] = py;
    write_register(CFG_PAD_Y, data);
    data = CFG_DATA_W'($urandom);
    data[SCALE_W-1:0] = sx;
    write_register(CFG_SCALE_X, data);
    data = CFG_DATA_W'($urandom);
    data[SCALE_W-1:0] = sy;
    write_register(CFG_SCALE_Y, data);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    in_word_t              w;
    int unsigned           sent, cut, pick;
    bit                    need_start;
    logic [VALUE_W-1:0]    script [24];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SCORE_THRESHOLD;
    cfg_data = '0;
    idle_on = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset settings. The first anchor has the largest
    // and smallest box words, a score exactly at the threshold, the most
    // negative score on the first class and a tie for the top score, where
    // the lower class must win. A partial anchor follows and is cut off by a
    // frame start, which must drop it and restart the count at anchor zero.
    script = '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
               24'h800000, 24'h00019A, 24'h000000, 24'h000000, 24'h000000,
               24'h7FFFFF, 24'h7FFFFE, 24'h7FFFFF, 24'h000001, 24'h000001,
               24'h000001, 24'h000001, 24'h000001,
               24'h001000, 24'h002000, 24'h004000, 24'h004000, 24'h7FFFFF,
               24'h7FFFFF, 24'h028000};
    for (int k = 0; k < 24; k++) begin
      w.value = script[k];
      w.frame_start = (k == 0) || (k == 23);
      push_word(w);
    end

    // Random phases, each under its own settings. The first two hold the
    // extremes: a zero threshold with the largest scales, then the largest
    // threshold and padding. The third has a zero horizontal scale, so every
    // box is too narrow. Most traffic is whole anchors; some is loose words
    // with random frame starts, and some is anchors cut short.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      idle_on = ($urandom_range(0, 4) != 0);
      case (p)
        0: apply_settings('0, '0, '0, '1, '1);
        1: apply_settings('1, '1, '1, SCALE_W'(4096), SCALE_W'(4096));
        2: apply_settings(CONF_W'($urandom_range(0, 4096)), PAD_W'($urandom),
                          PAD_W'($urandom), '0, SCALE_W'($urandom_range(2048, 8192)));
        default: apply_settings(
                   ($urandom_range(0, 3) == 0) ? CONF_W'($urandom)
                                               : CONF_W'($urandom_range(0, 6000)),
                   PAD_W'($urandom), PAD_W'($urandom),
                   ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom)
                                               : SCALE_W'($urandom_range(1024, 16384)),
                   ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom)
                                               : SCALE_W'($urandom_range(1024, 16384)));
      endcase
      @(negedge clk);
      sent = 0;
      need_start = 1'b1;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          repeat ($urandom_range(1, 6)) begin
            w.value = VALUE_W'($urandom);
            w.frame_start = ($urandom_range(0, 7) == 0);
            push_word(w);
            sent++;
          end
          need_start = 1'b1;
        end else if (pick == 1) begin
          cut = $urandom_range(1, ANCHOR_WORDS - 1);
          send_anchor(1'b1, cut, 1'b0);
          sent += cut;
          need_start = 1'b1;
        end else begin
          send_anchor(need_start || pick == 2, ANCHOR_WORDS, 1'b0);
          sent += ANCHOR_WORDS;
          need_start = 1'b0;
        end
      end
    end

    // Last part, with no idling on either side: a few whole anchors of a new
    // frame sent back to back at the reset settings.
    settle();
    idle_on = 1'b0;
    apply_settings(CONF_W'(410), '0, '0, SCALE_W'(4096), SCALE_W'(4096));
    @(negedge clk);
    for (int a = 0; a < LAST_ANCHORS; a++) begin
      send_anchor(a == 0, ANCHOR_WORDS, 1'b0);
    end
    settle();

    if (box_decoder.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
